/* rtl/core/tape_record_deframer_top_defines.svh */
// Assertion macros for the tape record deframer checks.
`ifndef TAPE_RECORD_DEFRAMER_TOP_DEFINES_SVH
`define TAPE_RECORD_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TRD_ASSERT_NOW(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TRD_ASSERT_NEXT(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

/* rtl/core/trd_pkg.sv */
// Shared types and constants for the tape record deframer.
package trd_pkg;

   localparam int unsigned WORD_W = 36;
   localparam int unsigned HALF_W = 18;
   localparam int unsigned POS_W  = 14;

   localparam int unsigned MAX_RECORD_WORDS_DEF = 10240;

   localparam logic [WORD_W-1:0] LABEL_MAGIC = 36'o444162640000;
   localparam logic [WORD_W-1:0] HEAD_MAGIC  = 36'o125045414412;
   localparam logic [WORD_W-1:0] TAIL_MAGIC  = 36'o126441515412;

   localparam logic [HALF_W-1:0] GAP_TYPE        = 18'o777767;
   localparam logic [HALF_W-1:0] START_TYPE_LOW  = 18'o777775;
   localparam logic [HALF_W:0]   LEVEL_BASE      = 19'o1000000;
   localparam logic [HALF_W-1:0] VERSION_LIMIT   = 18'd10;

   localparam logic [POS_W:0] TRAIL_WORDS    = 15'o30;
   localparam logic [POS_W:0] START_OFF_LOW  = 15'o22;
   localparam logic [POS_W:0] START_OFF_HIGH = 15'o44;
   localparam logic [POS_W:0] DATA_OFF_HIGH  = 15'o43;
   localparam logic [POS_W:0] DATA_OFF_LOW   = 15'o0;

   localparam logic [2:0] KIND_HEAD  = 3'd0;
   localparam logic [2:0] KIND_FILE  = 3'd1;
   localparam logic [2:0] KIND_META  = 3'd2;
   localparam logic [2:0] KIND_CHECK = 3'd3;
   localparam logic [2:0] KIND_GAP   = 3'd4;
   localparam logic [2:0] KIND_EOT   = 3'd5;
   localparam logic [2:0] KIND_ERROR = 3'd6;

   localparam logic [1:0] CLASS_DATA  = 2'd0;
   localparam logic [1:0] CLASS_START = 2'd1;
   localparam logic [1:0] CLASS_GAP   = 2'd2;
   localparam logic [1:0] CLASS_LABEL = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_EARLY_END = 3'd1;
   localparam logic [2:0] ERR_SHORT     = 3'd2;
   localparam logic [2:0] ERR_BAD_TYPE  = 3'd3;
   localparam logic [2:0] ERR_LONG      = 3'd4;
   localparam logic [2:0] ERR_EMPTY     = 3'd5;

   localparam logic [1:0] LEVEL_TOP   = 2'd3;
   localparam logic [1:0] LEVEL_RESET = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] tape_word;
      logic              record_start;
      logic              end_of_tape;
   } req_type;

   typedef struct packed {
      logic [2:0]        word_kind;
      logic [1:0]        record_class;
      logic [WORD_W-1:0] word_value;
      logic [POS_W-1:0]  word_position;
      logic              check_good;
      logic              file_finished;
      logic [2:0]        error_code;
      logic [1:0]        format_level;
      logic [3:0]        label_version;
      logic              trailer_seen;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

/* rtl/core/trd_in_stage.sv */
// Input register for request transactions.
module trd_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  trd_pkg::req_type req_item,
   input  logic             take,
   output logic             item_valid,
   output trd_pkg::req_type item
);

   logic             valid_ff;
   logic             valid_in;
   trd_pkg::req_type item_ff;
   logic             load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/core/trd_core.sv */
// Record framing state and per-word classification and checks.
module trd_core #(
   parameter int unsigned MAX_RECORD_WORDS = trd_pkg::MAX_RECORD_WORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  trd_pkg::hs_type  step,
   input  trd_pkg::req_type item,
   output logic             result_valid,
   output trd_pkg::rsp_type result
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_HEAD,
      PH_BODY,
      PH_SUM,
      PH_GAPCNT,
      PH_GAPSKIP
   } phase_type;

   localparam logic [trd_pkg::HALF_W-1:0] MAX_WORDS = trd_pkg::HALF_W'(MAX_RECORD_WORDS);

   phase_type                      phase_ff,   phase_in;
   logic [1:0]                     kind_ff,    kind_in;
   logic [trd_pkg::POS_W-1:0]      len_ff,     len_in;
   logic [trd_pkg::POS_W-1:0]      idx_ff,     idx_in;
   logic [trd_pkg::WORD_W-1:0]     check_ff,   check_in;
   logic [trd_pkg::WORD_W-1:0]     gap_ff,     gap_in;
   logic [1:0]                     level_ff,   level_in;
   logic [3:0]                     version_ff, version_in;
   logic                           tail_ff,    tail_in;
   logic                           halted_ff,  halted_in;

   logic                           update;
   logic [trd_pkg::WORD_W-1:0]     w;
   logic [trd_pkg::HALF_W-1:0]     lh;
   logic [trd_pkg::HALF_W-1:0]     rh;
   logic                           high;
   logic [trd_pkg::POS_W:0]        idx_wide;
   logic [trd_pkg::POS_W:0]        idx_next;
   logic [trd_pkg::POS_W:0]        data_base;
   logic [trd_pkg::POS_W:0]        data_off;
   logic                           file_data;
   logic [trd_pkg::WORD_W-1:0]     rotated;
   logic [trd_pkg::WORD_W-1:0]     gap_dec;

   assign update       = step.valid && step.ready && !halted_ff;
   assign result_valid = step.valid && !halted_ff;

   assign w        = item.tape_word;
   assign lh       = w[trd_pkg::WORD_W-1:trd_pkg::HALF_W];
   assign rh       = w[trd_pkg::HALF_W-1:0];
   assign high     = (level_ff == trd_pkg::LEVEL_TOP);
   assign idx_wide = {1'b0, idx_ff};
   assign idx_next = idx_wide + 15'd1;
   assign rotated  = {check_ff[trd_pkg::WORD_W-2:0], check_ff[trd_pkg::WORD_W-1]} + w;
   assign gap_dec  = gap_ff - 36'd1;

   always_comb begin
      if (kind_ff == trd_pkg::CLASS_START) begin
         data_base = idx_next;
         data_off  = high ? trd_pkg::START_OFF_HIGH : trd_pkg::START_OFF_LOW;
      end else begin
         data_base = idx_wide;
         data_off  = high ? trd_pkg::DATA_OFF_HIGH : trd_pkg::DATA_OFF_LOW;
      end
      file_data = (data_base >= data_off) &&
                  (!high || ((idx_wide + trd_pkg::TRAIL_WORDS) < {1'b0, len_ff}));
   end

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      check_in   = check_ff;
      gap_in     = gap_ff;
      level_in   = level_ff;
      version_in = version_ff;
      tail_in    = tail_ff;
      halted_in  = halted_ff;
      result     = '0;
      result.word_value = w;

      if (phase_ff == PH_FIRST || phase_ff == PH_HEAD) begin
         if (item.end_of_tape) begin
            halted_in = 1'b1;
            if (phase_ff == PH_FIRST) begin
               result.word_kind  = trd_pkg::KIND_ERROR;
               result.error_code = trd_pkg::ERR_EMPTY;
            end else begin
               result.word_kind = trd_pkg::KIND_EOT;
            end
         end else begin
            result.file_finished = (phase_ff == PH_HEAD) && (lh != '0) &&
                                   (kind_ff == trd_pkg::CLASS_DATA ||
                                    kind_ff == trd_pkg::CLASS_START);
            tail_in = 1'b0;
            result.word_kind = trd_pkg::KIND_HEAD;
            priority if (lh == '0) begin
               kind_in = trd_pkg::CLASS_DATA;
            end else if (lh >= trd_pkg::START_TYPE_LOW) begin
               kind_in  = trd_pkg::CLASS_START;
               level_in = 2'(trd_pkg::LEVEL_BASE - {1'b0, lh});
            end else if (lh == trd_pkg::GAP_TYPE) begin
               kind_in = trd_pkg::CLASS_GAP;
            end else if (lh < trd_pkg::VERSION_LIMIT) begin
               kind_in    = trd_pkg::CLASS_LABEL;
               version_in = lh[3:0];
            end else begin
               result.word_kind  = trd_pkg::KIND_ERROR;
               result.error_code = trd_pkg::ERR_BAD_TYPE;
            end
            if (result.word_kind == trd_pkg::KIND_HEAD &&
                kind_in != trd_pkg::CLASS_GAP && rh > MAX_WORDS) begin
               result.word_kind  = trd_pkg::KIND_ERROR;
               result.error_code = trd_pkg::ERR_LONG;
            end
            if (result.word_kind == trd_pkg::KIND_ERROR) begin
               halted_in = 1'b1;
            end else begin
               idx_in   = '0;
               check_in = '0;
               if (kind_in == trd_pkg::CLASS_GAP) begin
                  len_in   = '0;
                  phase_in = PH_GAPCNT;
               end else begin
                  len_in = rh[trd_pkg::POS_W-1:0];
                  if (rh != '0) begin
                     phase_in = PH_BODY;
                  end else if (kind_in == trd_pkg::CLASS_LABEL) begin
                     phase_in = PH_HEAD;
                  end else begin
                     phase_in = PH_SUM;
                  end
               end
            end
         end
      end else if (item.end_of_tape) begin
         result.word_kind     = trd_pkg::KIND_ERROR;
         result.error_code    = trd_pkg::ERR_EARLY_END;
         result.word_position = idx_ff;
         halted_in            = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_BODY: begin
               result.word_position = idx_ff;
               if (item.record_start) begin
                  result.word_kind  = trd_pkg::KIND_ERROR;
                  result.error_code = trd_pkg::ERR_SHORT;
                  halted_in         = 1'b1;
               end else begin
                  if (kind_ff == trd_pkg::CLASS_LABEL) begin
                     result.word_kind = trd_pkg::KIND_META;
                     if (idx_ff == 14'd0) begin
                        result.check_good = (w == trd_pkg::LABEL_MAGIC);
                     end
                     if (idx_ff == 14'd1) begin
                        result.check_good = (w == trd_pkg::HEAD_MAGIC) ||
                                            (w == trd_pkg::TAIL_MAGIC);
                        tail_in = (w == trd_pkg::TAIL_MAGIC);
                     end
                     if (len_ff > 14'd5 && !tail_in) begin
                        if (idx_next < {1'b0, len_ff}) begin
                           check_in = rotated;
                        end else begin
                           result.word_kind  = trd_pkg::KIND_CHECK;
                           result.check_good = (w == check_ff);
                        end
                     end
                  end else begin
                     check_in = check_ff ^ w;
                     result.word_kind = file_data ? trd_pkg::KIND_FILE : trd_pkg::KIND_META;
                  end
                  idx_in = idx_next[trd_pkg::POS_W-1:0];
                  if (idx_next >= {1'b0, len_ff}) begin
                     phase_in = (kind_ff == trd_pkg::CLASS_LABEL) ? PH_HEAD : PH_SUM;
                  end
               end
            end
            PH_SUM: begin
               result.word_kind     = trd_pkg::KIND_CHECK;
               result.word_position = idx_ff;
               result.check_good    = (w == check_ff);
               phase_in             = PH_HEAD;
            end
            PH_GAPCNT: begin
               result.word_kind = trd_pkg::KIND_GAP;
               gap_in           = w;
               idx_in           = 14'd1;
               phase_in         = (w == '0) ? PH_HEAD : PH_GAPSKIP;
            end
            PH_GAPSKIP: begin
               result.word_kind     = trd_pkg::KIND_GAP;
               result.word_position = idx_ff;
               idx_in               = idx_next[trd_pkg::POS_W-1:0];
               gap_in               = gap_dec;
               if (gap_dec == '0) begin
                  phase_in = PH_HEAD;
               end
            end
            default: begin
               halted_in = 1'b1;
            end
         endcase
      end

      result.record_class  = kind_in;
      result.format_level  = level_in;
      result.label_version = version_in;
      result.trailer_seen  = tail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FIRST;
         kind_ff    <= trd_pkg::CLASS_DATA;
         len_ff     <= '0;
         idx_ff     <= '0;
         check_ff   <= '0;
         gap_ff     <= '0;
         level_ff   <= trd_pkg::LEVEL_RESET;
         version_ff <= '0;
         tail_ff    <= 1'b0;
         halted_ff  <= 1'b0;
      end else if (update) begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         check_ff   <= check_in;
         gap_ff     <= gap_in;
         level_ff   <= level_in;
         version_ff <= version_in;
         tail_ff    <= tail_in;
         halted_ff  <= halted_in;
      end
   end

endmodule

/* rtl/core/trd_out_stage.sv */
// Result register for response transactions.
module trd_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             result_valid,
   input  trd_pkg::rsp_type result,
   output logic             out_ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output trd_pkg::rsp_type rsp_item
);

   logic             valid_ff;
   logic             valid_in;
   trd_pkg::rsp_type item_ff;
   logic             load;

   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = out_ready && result_valid;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

/* rtl/core/tape_record_deframer_top.sv */
// Top level of the tape record deframer.
//
// Request channel (req_): one 36-bit tape word per transaction with its
// record-start and end-of-tape marks. Response channel (rsp_): one result per
// word, carrying the word kind, record class, position in the record body,
// checksum and magic outcome, file-end flag, error code and the current format
// level, label version and tail-label flag.
// Each word passes through the input register, then the classification and
// check logic into the result register. Throughput is one word per cycle while
// rsp_stall is low; the framing state updates in the same cycle the word moves
// into the result register.
// Reset clears both registers and all framing state (format level returns to 2).
// While rsp_stall is high the result holds, one more word waits in the input
// register, and req_stall rises until the result is taken.
// After an error result or the end-of-tape result, further words are consumed
// without response until reset.
module tape_record_deframer_top #(
   parameter int unsigned MAX_RECORD_WORDS = trd_pkg::MAX_RECORD_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [35:0] req_tape_word,
   input  logic        req_record_start,
   input  logic        req_end_of_tape,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_word_kind,
   output logic [1:0]  rsp_record_class,
   output logic [35:0] rsp_word_value,
   output logic [13:0] rsp_word_position,
   output logic        rsp_check_good,
   output logic        rsp_file_finished,
   output logic [2:0]  rsp_error_code,
   output logic [1:0]  rsp_format_level,
   output logic [3:0]  rsp_label_version,
   output logic        rsp_trailer_seen
);

   trd_pkg::req_type req_item;
   trd_pkg::req_type item;
   logic             item_valid;
   trd_pkg::hs_type  step;
   logic             result_valid;
   trd_pkg::rsp_type result;
   logic             out_ready;
   trd_pkg::rsp_type rsp_item;

   assign req_item.tape_word    = req_tape_word;
   assign req_item.record_start = req_record_start;
   assign req_item.end_of_tape  = req_end_of_tape;

   assign step.valid = item_valid;
   assign step.ready = out_ready;

   trd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (item_valid && out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   trd_core #(
      .MAX_RECORD_WORDS (MAX_RECORD_WORDS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (item),
      .result_valid (result_valid),
      .result       (result)
   );

   trd_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .out_ready    (out_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item)
   );

   assign rsp_word_kind     = rsp_item.word_kind;
   assign rsp_record_class  = rsp_item.record_class;
   assign rsp_word_value    = rsp_item.word_value;
   assign rsp_word_position = rsp_item.word_position;
   assign rsp_check_good    = rsp_item.check_good;
   assign rsp_file_finished = rsp_item.file_finished;
   assign rsp_error_code    = rsp_item.error_code;
   assign rsp_format_level  = rsp_item.format_level;
   assign rsp_label_version = rsp_item.label_version;
   assign rsp_trailer_seen  = rsp_item.trailer_seen;

endmodule

/* rtl/core/trd_checker.sv */
// Port-level checks for the tape record deframer, bound to the top level.
`include "tape_record_deframer_top_defines.svh"

module trd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_word_kind,
   input logic [35:0] rsp_word_value,
   input logic [13:0] rsp_word_position,
   input logic        rsp_file_finished,
   input logic [2:0]  rsp_error_code
);

   logic rsp_done;
   logic stop_kind;
   logic head_kind;

   assign rsp_done  = rsp_valid && !rsp_stall;
   assign stop_kind = (rsp_word_kind == trd_pkg::KIND_ERROR) ||
                      (rsp_word_kind == trd_pkg::KIND_EOT);
   assign head_kind = (rsp_word_kind == trd_pkg::KIND_HEAD) ||
                      (rsp_word_kind == trd_pkg::KIND_ERROR);

   `TRD_ASSERT_NEXT(a_silent_after_stop, clock, reset, rsp_done && stop_kind, !rsp_valid, "response after stop")

   `TRD_ASSERT_NEXT(a_stalled_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word_value) && $stable(rsp_word_kind), "stalled response changed")

   `TRD_ASSERT_NOW(a_error_code_match, clock, reset, rsp_valid, (rsp_word_kind == trd_pkg::KIND_ERROR) == (rsp_error_code != trd_pkg::ERR_NONE), "error code and kind disagree")

   `TRD_ASSERT_NOW(a_finish_on_head, clock, reset, rsp_valid && rsp_file_finished, head_kind && rsp_word_position == 14'd0, "file end outside a head")

endmodule

bind tape_record_deframer_top trd_checker u_checker (.*);

/* dv/tape_record_deframer_top_tb.sv */
// Self-checking testbench for the tape record deframer: record stimulus, prediction, scoreboard.
`timescale 1ns / 1ps

module tape_record_deframer_top_tb;

   localparam int unsigned MAX_WORDS    = trd_pkg::MAX_RECORD_WORDS_DEF;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned RANDOM_ITEMS = 360;
   localparam int unsigned PRINT_LIMIT  = 40;

   typedef enum logic [2:0] {
      FR_FIRST, FR_HEAD, FR_BODY, FR_SUM, FR_GAP_COUNT, FR_GAP_SKIP
   } frame_phase_type;

   typedef enum int {
      END_AT_HEAD, END_EARLY, END_SHORT, END_BAD_TYPE, END_LONG
   } tape_end_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [35:0] req_tape_word = '0;
   logic        req_record_start = 1'b0;
   logic        req_end_of_tape = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_word_kind;
   logic [1:0]  rsp_record_class;
   logic [35:0] rsp_word_value;
   logic [13:0] rsp_word_position;
   logic        rsp_check_good;
   logic        rsp_file_finished;
   logic [2:0]  rsp_error_code;
   logic [1:0]  rsp_format_level;
   logic [3:0]  rsp_label_version;
   logic        rsp_trailer_seen;

   tape_record_deframer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_tape_word     (req_tape_word),
      .req_record_start  (req_record_start),
      .req_end_of_tape   (req_end_of_tape),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word_kind     (rsp_word_kind),
      .rsp_record_class  (rsp_record_class),
      .rsp_word_value    (rsp_word_value),
      .rsp_word_position (rsp_word_position),
      .rsp_check_good    (rsp_check_good),
      .rsp_file_finished (rsp_file_finished),
      .rsp_error_code    (rsp_error_code),
      .rsp_format_level  (rsp_format_level),
      .rsp_label_version (rsp_label_version),
      .rsp_trailer_seen  (rsp_trailer_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_ticket = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned words_sent = 0;
   int unsigned results_checked = 0;
   int unsigned fail_count = 0;
   string       end_name = "none";

   trd_pkg::rsp_type expected_results [$];
   trd_pkg::rsp_type want;

   // Deframer state as predicted
   frame_phase_type fr_phase = FR_FIRST;
   logic [1:0]      fr_class = trd_pkg::CLASS_DATA;
   logic [13:0]     fr_len = '0;
   logic [13:0]     fr_index = '0;
   logic [35:0]     fr_check = '0;
   logic [35:0]     fr_gap_left = '0;
   logic [1:0]      fr_level = trd_pkg::LEVEL_RESET;
   logic [3:0]      fr_version = '0;
   logic            fr_tail = 1'b0;
   logic            fr_halted = 1'b0;

   function automatic bit is_file_data(input logic [13:0] i);
      logic [14:0] b;
      logic [14:0] off;
      bit          high;
      high = (fr_level == trd_pkg::LEVEL_TOP);
      if (fr_class == trd_pkg::CLASS_START) begin
         b   = {1'b0, i} + 15'd1;
         off = high ? trd_pkg::START_OFF_HIGH : trd_pkg::START_OFF_LOW;
      end else begin
         b   = {1'b0, i};
         off = high ? trd_pkg::DATA_OFF_HIGH : trd_pkg::DATA_OFF_LOW;
      end
      if (b < off) return 1'b0;
      return !high || ({1'b0, i} + trd_pkg::TRAIL_WORDS < {1'b0, fr_len});
   endfunction

   task automatic predict_word(input logic [35:0] w, input logic rs, input logic eot,
                               output bit produced, output trd_pkg::rsp_type r);
      logic [17:0] lh;
      logic [17:0] rh;
      logic [18:0] lvl;
      logic [2:0]  kind;
      logic [2:0]  err;
      logic [13:0] pos;
      logic [13:0] i;
      logic        good;
      logic        fin;
      bit          ok;
      lh = w[35:18];
      rh = w[17:0];
      kind = trd_pkg::KIND_HEAD;
      err = trd_pkg::ERR_NONE;
      pos = '0;
      good = 1'b0;
      fin = 1'b0;
      produced = 1'b0;
      r = '0;
      if (!fr_halted) begin
         produced = 1'b1;
         if (fr_phase == FR_FIRST || fr_phase == FR_HEAD) begin
            if (eot) begin
               kind = (fr_phase == FR_FIRST) ? trd_pkg::KIND_ERROR : trd_pkg::KIND_EOT;
               err = (fr_phase == FR_FIRST) ? trd_pkg::ERR_EMPTY : trd_pkg::ERR_NONE;
               fr_halted = 1'b1;
            end else begin
               ok = 1'b1;
               if (fr_phase == FR_HEAD && fr_class <= trd_pkg::CLASS_START && lh != 0)
                  fin = 1'b1;
               fr_tail = 1'b0;
               if (lh == 0) begin
                  fr_class = trd_pkg::CLASS_DATA;
               end else if (lh >= trd_pkg::START_TYPE_LOW) begin
                  fr_class = trd_pkg::CLASS_START;
                  lvl = trd_pkg::LEVEL_BASE - {1'b0, lh};
                  fr_level = lvl[1:0];
               end else if (lh == trd_pkg::GAP_TYPE) begin
                  fr_class = trd_pkg::CLASS_GAP;
               end else if (lh < trd_pkg::VERSION_LIMIT) begin
                  fr_class = trd_pkg::CLASS_LABEL;
                  fr_version = lh[3:0];
               end else begin
                  ok = 1'b0;
                  err = trd_pkg::ERR_BAD_TYPE;
               end
               if (ok && fr_class != trd_pkg::CLASS_GAP && rh > MAX_WORDS) begin
                  ok = 1'b0;
                  err = trd_pkg::ERR_LONG;
               end
               if (!ok) begin
                  kind = trd_pkg::KIND_ERROR;
                  fr_halted = 1'b1;
               end else begin
                  fr_index = '0;
                  fr_check = '0;
                  if (fr_class == trd_pkg::CLASS_GAP) begin
                     fr_len = '0;
                     fr_phase = FR_GAP_COUNT;
                  end else begin
                     fr_len = rh[13:0];
                     if (rh != 0) fr_phase = FR_BODY;
                     else if (fr_class == trd_pkg::CLASS_LABEL) fr_phase = FR_HEAD;
                     else fr_phase = FR_SUM;
                  end
               end
            end
         end else if (eot) begin
            kind = trd_pkg::KIND_ERROR;
            err = trd_pkg::ERR_EARLY_END;
            pos = fr_index;
            fr_halted = 1'b1;
         end else if (fr_phase == FR_BODY) begin
            i = fr_index;
            pos = i;
            if (rs) begin
               kind = trd_pkg::KIND_ERROR;
               err = trd_pkg::ERR_SHORT;
               fr_halted = 1'b1;
            end else begin
               if (fr_class == trd_pkg::CLASS_LABEL) begin
                  kind = trd_pkg::KIND_META;
                  if (i == 0) good = (w == trd_pkg::LABEL_MAGIC);
                  if (i == 1) begin
                     good = (w == trd_pkg::HEAD_MAGIC || w == trd_pkg::TAIL_MAGIC);
                     fr_tail = (w == trd_pkg::TAIL_MAGIC);
                  end
                  if (fr_len > 5 && !fr_tail) begin
                     if ({1'b0, i} + 15'd1 < {1'b0, fr_len}) begin
                        fr_check = {fr_check[34:0], fr_check[35]} + w;
                     end else begin
                        kind = trd_pkg::KIND_CHECK;
                        good = (w == fr_check);
                     end
                  end
               end else begin
                  fr_check = fr_check ^ w;
                  kind = is_file_data(i) ? trd_pkg::KIND_FILE : trd_pkg::KIND_META;
               end
               fr_index = i + 14'd1;
               if (fr_index >= fr_len) begin
                  if (fr_class == trd_pkg::CLASS_LABEL) fr_phase = FR_HEAD;
                  else fr_phase = FR_SUM;
               end
            end
         end else if (fr_phase == FR_SUM) begin
            kind = trd_pkg::KIND_CHECK;
            pos = fr_index;
            good = (w == fr_check);
            fr_phase = FR_HEAD;
         end else if (fr_phase == FR_GAP_COUNT) begin
            kind = trd_pkg::KIND_GAP;
            fr_gap_left = w;
            fr_index = 14'd1;
            if (w == 0) fr_phase = FR_HEAD;
            else fr_phase = FR_GAP_SKIP;
         end else begin
            kind = trd_pkg::KIND_GAP;
            pos = fr_index;
            fr_index = fr_index + 14'd1;
            fr_gap_left = fr_gap_left - 36'd1;
            if (fr_gap_left == 0) fr_phase = FR_HEAD;
         end
         r.word_kind     = kind;
         r.record_class  = fr_class;
         r.word_value    = w;
         r.word_position = pos;
         r.check_good    = good;
         r.file_finished = fin;
         r.error_code    = err;
         r.format_level  = fr_level;
         r.label_version = fr_version;
         r.trailer_seen  = fr_tail;
      end
   endtask

   function automatic logic [35:0] rand_word();
      logic [63:0] t;
      t = {$urandom, $urandom};
      return t[35:0];
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [35:0] flip_bit();
      return 36'd1 << $urandom_range(35);
   endfunction

   function automatic logic [17:0] rand_len();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 70) return 18'($urandom_range(8));
      if (p < 95) return 18'($urandom_range(80, 9));
      return 18'($urandom_range(200, 81));
   endfunction

   task automatic send_word(input logic [35:0] w, input logic rs, input logic eot);
      bit               produced;
      trd_pkg::rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_tape_word    <= w;
      req_record_start <= rs;
      req_end_of_tape  <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(w, rs, eot, produced, r);
      words_sent++;
      if (produced) expected_results.push_back(r);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_xor_record(input logic [17:0] lh, input logic [17:0] len,
                                  input bit sum_ok);
      logic [35:0] sum;
      logic [35:0] w;
      sum = '0;
      send_word({lh, len}, rand_bit(), 1'b0);
      for (int k = 0; k < len; k++) begin
         w = rand_word();
         sum = sum ^ w;
         send_word(w, 1'b0, 1'b0);
      end
      send_word(sum_ok ? sum : sum ^ flip_bit(), rand_bit(), 1'b0);
   endtask

   task automatic send_label(input logic [3:0] ver, input logic [17:0] len,
                             input logic [35:0] w0, input logic [35:0] w1, input bit sum_ok);
      logic [35:0] body [$];
      logic [35:0] sum;
      for (int k = 0; k < len; k++)
         body.push_back((k == 0) ? w0 : (k == 1) ? w1 : rand_word());
      if (len > 5 && w1 != trd_pkg::TAIL_MAGIC) begin
         sum = '0;
         for (int k = 0; k + 1 < len; k++) sum = {sum[34:0], sum[35]} + body[k];
         body[len-1] = sum_ok ? sum : sum ^ flip_bit();
      end
      send_word({14'd0, ver, len}, rand_bit(), 1'b0);
      foreach (body[k]) send_word(body[k], 1'b0, 1'b0);
   endtask

   task automatic send_gap(input logic [35:0] count);
      logic [35:0] h;
      h = rand_word();
      send_word({trd_pkg::GAP_TYPE, h[17:0]}, rand_bit(), 1'b0);
      send_word(count, rand_bit(), 1'b0);
      for (int k = 0; k < count; k++) send_word(rand_word(), rand_bit(), 1'b0);
   endtask

   task automatic send_random_record();
      int unsigned pick;
      int unsigned p2;
      logic [17:0] len;
      logic [35:0] w1;
      pick = $urandom_range(99);
      len = rand_len();
      if (pick < 35) begin
         send_xor_record(18'd0, len, $urandom_range(3) != 0);
      end else if (pick < 55) begin
         send_xor_record(trd_pkg::START_TYPE_LOW + 18'($urandom_range(2)), len,
                         $urandom_range(3) != 0);
      end else if (pick < 80) begin
         p2 = $urandom_range(99);
         if (p2 < 45) w1 = trd_pkg::HEAD_MAGIC;
         else if (p2 < 80) w1 = trd_pkg::TAIL_MAGIC;
         else w1 = rand_word();
         send_label(4'($urandom_range(9, 1)), len,
                    ($urandom_range(4) != 0) ? trd_pkg::LABEL_MAGIC : rand_word(), w1,
                    $urandom_range(3) != 0);
      end else begin
         send_gap(36'($urandom_range(5)));
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 33;
      recv_idle_pct = 63;
      send_xor_record(trd_pkg::START_TYPE_LOW, 18'd0, 1'b1);
      send_xor_record(18'd0, 18'd0, 1'b0);
      send_xor_record(trd_pkg::START_TYPE_LOW + 18'd2, 18'd2, 1'b1);
      send_label(4'd1, 18'd0, trd_pkg::LABEL_MAGIC, trd_pkg::HEAD_MAGIC, 1'b1);
      send_gap(36'd0);
      send_gap(36'd2);
      send_label(4'd9, 18'd6, trd_pkg::LABEL_MAGIC, trd_pkg::HEAD_MAGIC, 1'b1);
      send_label(4'd3, 18'd3, trd_pkg::LABEL_MAGIC, trd_pkg::TAIL_MAGIC, 1'b1);
      wait_drain();
   endtask

   task automatic test_random_traffic(input int unsigned items, input int unsigned sp,
                                      input int unsigned rp);
      int unsigned first;
      first = words_sent;
      send_idle_pct = sp;
      recv_idle_pct = rp;
      while (words_sent - first < items) send_random_record();
      wait_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_ticket++;
      repeat (6) send_random_record();
      wait_drain();
   endtask

   task automatic test_long_records();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_xor_record(trd_pkg::START_TYPE_LOW, 18'd100, 1'b1);
      send_xor_record(18'd0, 18'd90, 1'b1);
      send_label(4'($urandom_range(9, 1)), 18'd60, trd_pkg::LABEL_MAGIC,
                 trd_pkg::HEAD_MAGIC, 1'b1);
      send_gap(36'd30);
      wait_drain();
   endtask

   task automatic test_tape_end();
      tape_end_type how;
      logic [17:0]  lh;
      logic [17:0]  rh;
      how = tape_end_type'($urandom_range(4));
      send_idle_pct = 33;
      recv_idle_pct = 33;
      case (how)
         END_AT_HEAD: begin
            end_name = "end-of-tape at a head";
            send_word(rand_word(), rand_bit(), 1'b1);
         end
         END_EARLY: begin
            end_name = "early end";
            case ($urandom_range(3))
               0: begin
                  send_word({18'd0, 18'd5}, 1'b1, 1'b0);
                  repeat (2) send_word(rand_word(), 1'b0, 1'b0);
               end
               1: begin
                  send_word({18'd0, 18'd2}, 1'b1, 1'b0);
                  repeat (2) send_word(rand_word(), 1'b0, 1'b0);
               end
               2: send_word({trd_pkg::GAP_TYPE, 18'd0}, 1'b1, 1'b0);
               default: begin
                  send_word({trd_pkg::GAP_TYPE, 18'd0}, 1'b1, 1'b0);
                  send_word(36'd5, 1'b0, 1'b0);
                  repeat (2) send_word(rand_word(), 1'b0, 1'b0);
               end
            endcase
            send_word(rand_word(), rand_bit(), 1'b1);
         end
         END_SHORT: begin
            end_name = "start mark inside a body";
            lh = $urandom_range(1) ? 18'd0 : 18'd3;
            send_word({lh, 18'd4}, 1'b1, 1'b0);
            send_word(rand_word(), 1'b0, 1'b0);
            send_word(rand_word(), 1'b1, 1'b0);
         end
         END_BAD_TYPE: begin
            end_name = "bad record type";
            if ($urandom_range(1)) lh = 18'($urandom_range(18'o777766, 10));
            else lh = 18'($urandom_range(18'o777774, 18'o777770));
            rh = 18'($urandom_range(18'o777777));
            send_word({lh, rh}, rand_bit(), 1'b0);
         end
         default: begin
            end_name = "record too long";
            case ($urandom_range(2))
               0: lh = 18'd0;
               1: lh = trd_pkg::START_TYPE_LOW + 18'($urandom_range(2));
               default: lh = 18'($urandom_range(9, 1));
            endcase
            rh = 18'($urandom_range(18'o777777, MAX_WORDS + 1));
            send_word({lh, rh}, rand_bit(), 1'b0);
         end
      endcase
      // stopped: consume words, expect nothing
      repeat (20) send_word(rand_word(), rand_bit(), rand_bit());
      wait_drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_ticket) begin
         hold_seen  <= hold_ticket;
         hold_count <= HOLD_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic compare_field(input string name, input logic [35:0] exp_val,
                                input logic [35:0] act_val);
      if (exp_val !== act_val) begin
         fail_count++;
         if (fail_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT)
               $display("%0t: unexpected result, expected none, actual kind %0d word %0h",
                        $time, rsp_word_kind, rsp_word_value);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            compare_field("word_kind", 36'(want.word_kind), 36'(rsp_word_kind));
            compare_field("record_class", 36'(want.record_class), 36'(rsp_record_class));
            compare_field("word_value", want.word_value, rsp_word_value);
            compare_field("word_position", 36'(want.word_position), 36'(rsp_word_position));
            compare_field("check_good", 36'(want.check_good), 36'(rsp_check_good));
            compare_field("file_finished", 36'(want.file_finished), 36'(rsp_file_finished));
            compare_field("error_code", 36'(want.error_code), 36'(rsp_error_code));
            compare_field("format_level", 36'(want.format_level), 36'(rsp_format_level));
            compare_field("label_version", 36'(want.label_version), 36'(rsp_label_version));
            compare_field("trailer_seen", 36'(want.trailer_seen), 36'(rsp_trailer_seen));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, expected_results.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(RANDOM_ITEMS / 3, 33, 63);
      test_random_traffic(RANDOM_ITEMS / 3, 63, 33);
      test_random_traffic(RANDOM_ITEMS / 3, 0, 0);
      test_backpressure();
      test_long_records();
      test_tape_end();
      repeat (8) @(posedge clock);
      $display("Sent %0d tape words in data, file-start, label and gap records; %0d checked,",
               words_sent, results_checked);
      $display("with bad sums and magics, long records, stalls and a %s ending.", end_name);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
